// ===== rtl/lmc_pkg.sv =====
// ----------------------------------------------------------------------------
// lmc_pkg
// shared widths, command codes and register map for the logistic-map cipher
// ----------------------------------------------------------------------------
package lmc_pkg;

    localparam int CMD_W    = 1;
    localparam int SIDX_W   = 4;
    localparam int VAL_W    = 32;
    localparam int PIX_W    = 8;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam int CFG_W    = 4;
    localparam int GROUP_LEN = 6;

    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [SIDX_W-1:0]  t_sidx;
    typedef logic [VAL_W-1:0]   t_val;
    typedef logic [PIX_W-1:0]   t_pix;
    typedef logic [PADDR_W-1:0] t_paddr;
    typedef logic [PDATA_W-1:0] t_pdata;
    typedef logic [CFG_W-1:0]   t_cfg;
    typedef logic [2:0]         t_phase;

    localparam t_cmd CMD_SEED  = 1'b0;
    localparam t_cmd CMD_PIXEL = 1'b1;

    localparam logic REG_START_MAP = 1'b0;

endpackage

// ===== rtl/lmc_in_if.sv =====
// ----------------------------------------------------------------------------
// lmc_in_if
// input channel: seed or pixel transaction with valid/ready handshake
// ----------------------------------------------------------------------------
interface lmc_in_if;
    import lmc_pkg::*;

    logic  valid;
    logic  ready;
    t_cmd  cmd;
    t_sidx seed_index;
    t_val  seed_value;
    t_pix  pixel;

    modport source (output valid, output cmd, output seed_index, output seed_value,
                    output pixel, input ready);
    modport sink   (input valid, input cmd, input seed_index, input seed_value,
                    input pixel, output ready);
endinterface

// ===== rtl/lmc_out_if.sv =====
// ----------------------------------------------------------------------------
// lmc_out_if
// output channel: one ciphered pixel per transaction
// ----------------------------------------------------------------------------
interface lmc_out_if;
    import lmc_pkg::*;

    logic valid;
    logic ready;
    t_pix cipher_pixel;

    modport source (output valid, output cipher_pixel, input ready);
    modport sink   (input valid, input cipher_pixel, output ready);
endinterface

// ===== rtl/lmc_regs.sv =====
// ----------------------------------------------------------------------------
// lmc_regs
// apb register block holding the start map index
// ----------------------------------------------------------------------------
module lmc_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  lmc_pkg::t_paddr paddr,
    input  lmc_pkg::t_pdata pwdata,
    output lmc_pkg::t_pdata prdata,
    output logic            pready,
    output lmc_pkg::t_cfg   o_start_map
);
    import lmc_pkg::*;

    t_cfg r_start_map;
    logic wr_start;

    assign pready   = 1'b1;
    assign wr_start = psel && penable && pwrite && (paddr[2] == REG_START_MAP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_map <= '0;
        end else if (wr_start) begin
            r_start_map <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_START_MAP) begin
            prdata = {{(PDATA_W-CFG_W){1'b0}}, r_start_map};
        end
    end

    assign o_start_map = r_start_map;
endmodule

// ===== rtl/chaotic_map_pixel_xor_cipher.sv =====
// ----------------------------------------------------------------------------
// chaotic_map_pixel_xor_cipher
// logistic-map pixel xor cipher with map values held in a synchronous memory
// ----------------------------------------------------------------------------
// channel  | dir | handshake              | payload
// i_in     | in  | valid/ready            | cmd, seed_index, seed_value, pixel
// o_out    | out | valid/ready            | cipher_pixel
// apb      | in  | psel/penable, pready=1 | start_map at byte address 0
//
// a seed transaction writes the map memory directly when it is accepted
// a pixel transaction runs through memory read, multiply, saturate, key
// and write-back; the next pixel waits for the write-back of the previous one
// a full output register stalls the key stage until the result is taken
// synchronous reset clears control state; map memory is not cleared
// ----------------------------------------------------------------------------
module chaotic_map_pixel_xor_cipher #(
    parameter int NUM_MAPS = 10
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    lmc_in_if.sink          i_in,
    lmc_out_if.source       o_out,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  lmc_pkg::t_paddr paddr,
    input  lmc_pkg::t_pdata pwdata,
    output lmc_pkg::t_pdata prdata,
    output logic            pready
);
    import lmc_pkg::*;

    localparam int MAP_W = (NUM_MAPS > 1) ? $clog2(NUM_MAPS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_SAT, S_KEY} t_state;

    function automatic logic [MAP_W-1:0] f_mod(input logic [7:0] v);
        logic [11:0] rem;
        logic [11:0] dv;
        rem = {4'b0, v};
        for (int j = 7; j >= 0; j--) begin
            dv = 12'(NUM_MAPS) << j;
            if (rem >= dv) begin
                rem = rem - dv;
            end
        end
        return rem[MAP_W-1:0];
    endfunction

    t_cfg start_map;

    lmc_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_start_map(start_map)
    );

    // map memory
    t_val r_mem [NUM_MAPS];
    t_val r_rd_data;

    t_state           r_state, n_state;
    logic [MAP_W-1:0] r_cur_map, n_cur_map;
    t_phase           r_phase, n_phase;
    logic             r_out_valid, n_out_valid;
    t_pix             r_out_pixel, n_out_pixel;
    t_pix             r_pixel;
    logic [63:0]      r_prod;
    t_val             r_x;
    t_val             r_nx;

    logic             acc;
    logic             seed_acc;
    logic             pix_acc;
    logic             key_load;
    logic             mem_we;
    logic [MAP_W-1:0] mem_wa;
    t_val             mem_wd;
    logic [63:0]      sum;
    t_val             nx;
    logic [39:0]      key_t;
    t_pix             key;

    assign i_in.ready = (r_state == S_IDLE);
    assign acc        = i_in.valid && i_in.ready;
    assign seed_acc   = acc && (i_in.cmd == CMD_SEED);
    assign pix_acc    = acc && (i_in.cmd == CMD_PIXEL);
    assign key_load   = (r_state == S_KEY) && (!r_out_valid || o_out.ready);

    // fixed-point step: x*(2^32-x) = x*~x + x, then >> 30 with saturation
    assign sum   = r_prod + {32'b0, r_x};
    assign nx    = (sum[63:62] != 2'b00) ? '1 : sum[61:30];
    assign key_t = {r_nx, 8'h00} - {8'h00, r_nx};
    assign key   = key_t[39:32];

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cur_map;
        mem_wd = r_nx;
        if (seed_acc && ({1'b0, i_in.seed_index} < 5'(NUM_MAPS))) begin
            mem_we = 1'b1;
            mem_wa = i_in.seed_index[MAP_W-1:0];
            mem_wd = i_in.seed_value;
        end else if (key_load) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (pix_acc) begin
            r_rd_data <= r_mem[r_cur_map];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_pixel <= i_in.pixel;
        end
        if (r_state == S_MUL) begin
            r_prod <= {32'b0, r_rd_data} * {32'b0, ~r_rd_data};
            r_x    <= r_rd_data;
        end
        if (r_state == S_SAT) begin
            r_nx <= nx;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cur_map   = r_cur_map;
        n_phase     = r_phase;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_pixel = r_out_pixel;
        case (r_state)
            S_IDLE: begin
                if (seed_acc) begin
                    n_cur_map = f_mod({4'b0, start_map});
                    n_phase   = '0;
                end else if (pix_acc) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_SAT;
            S_SAT: n_state = S_KEY;
            S_KEY: begin
                if (key_load) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_out_pixel = r_pixel ^ key;
                    if (r_phase >= 3'(GROUP_LEN - 1)) begin
                        n_phase = '0;
                    end else begin
                        n_phase   = r_phase + 3'd1;
                        n_cur_map = f_mod(key);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cur_map   <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cur_map   <= n_cur_map;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
        r_out_pixel <= n_out_pixel;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.cipher_pixel = r_out_pixel;

    a_map_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cur_map) < NUM_MAPS)
        else $error("current map index out of range");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_phase) < GROUP_LEN)
        else $error("group phase out of range");

    a_pix_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.cmd == CMD_PIXEL) |=> (r_state == S_MUL))
        else $error("pixel transaction did not start the step");

    a_key_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_KEY && (!r_out_valid || o_out.ready))
        |=> (r_state == S_IDLE && r_out_valid))
        else $error("key stage did not deliver a result");
endmodule

// ===== sim/chaotic_map_pixel_xor_cipher_test.sv =====
// ----------------------------------------------------------------------------
// chaotic_map_pixel_xor_cipher_test
// self-checking testbench for the logistic-map pixel xor cipher: seed and
// pixel transactions are driven in random bursts against a stalling result
// sink, every ciphered pixel is checked against an in-bench model of the map
// state, and start_map is swept through in-range and wrapping settings
// ----------------------------------------------------------------------------
module chaotic_map_pixel_xor_cipher_test;
    import lmc_pkg::*;

    localparam int     NUM_MAPS       = 10;
    localparam int     NUM_SETTINGS   = 6;
    localparam int     ITEMS_PER_RUN  = 270;
    localparam t_paddr ADDR_START_MAP = t_paddr'(4 * REG_START_MAP);
    localparam t_paddr ADDR_UNMAPPED  = t_paddr'(4);

    typedef struct {
        t_cmd  cmd;
        t_sidx seed_index;
        t_val  seed_value;
        t_pix  pixel;
    } cipher_item_t;

    logic   i_clk;
    logic   i_rst_n;
    logic   psel;
    logic   penable;
    logic   pwrite;
    t_paddr paddr;
    t_pdata pwdata;
    t_pdata prdata;
    logic   pready;

    lmc_in_if  in_ch ();
    lmc_out_if out_ch ();

    chaotic_map_pixel_xor_cipher #(
        .NUM_MAPS (NUM_MAPS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cipher_item_t pending_items[$];
    t_pix         expected_cipher[$];

    t_val   map_x [NUM_MAPS];
    int     cur_map;
    t_phase group_pos;
    t_cfg   start_map_cfg;

    logic in_taken;
    logic steady;
    int   burst_left;
    int   gap_left;
    int   run_left;
    int   stall_left;
    int   fail_count;
    int   seeds_seen;
    int   pixels_seen;
    int   pixels_checked;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("chaotic_map_pixel_xor_cipher_test failed");
        $finish;
    end

    function automatic t_val logistic_next(t_val x);
        logic [63:0] prod;
        logic [63:0] scaled;
        prod   = {32'd0, x} * (64'h1_0000_0000 - {32'd0, x});
        scaled = prod >> 30;
        return (scaled > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : scaled[31:0];
    endfunction

    function automatic void advance_cipher(cipher_item_t it);
        t_val        x;
        logic [63:0] wide;
        t_pix        key;
        int          m;
        if (it.cmd == CMD_SEED) begin
            seeds_seen++;
            if (it.seed_index < NUM_MAPS) map_x[it.seed_index] = it.seed_value;
            cur_map   = start_map_cfg % NUM_MAPS;
            group_pos = '0;
        end else begin
            pixels_seen++;
            m        = cur_map % NUM_MAPS;
            x        = logistic_next(map_x[m]);
            wide     = {32'd0, x} * 64'd255;
            key      = wide[39:32];
            map_x[m] = x;
            expected_cipher.push_back(it.pixel ^ key);
            if (group_pos >= GROUP_LEN - 1) begin
                group_pos = '0;
            end else begin
                group_pos++;
                cur_map = key % NUM_MAPS;
            end
        end
    endfunction

    function automatic void push_seed(t_sidx idx, t_val value);
        cipher_item_t it;
        it.cmd        = CMD_SEED;
        it.seed_index = idx;
        it.seed_value = value;
        it.pixel      = t_pix'($urandom);
        pending_items.push_back(it);
    endfunction

    function automatic void push_pixel(t_pix pix);
        cipher_item_t it;
        it.cmd        = CMD_PIXEL;
        it.seed_index = t_sidx'($urandom);
        it.seed_value = t_val'($urandom);
        it.pixel      = pix;
        pending_items.push_back(it);
    endfunction

    function automatic t_sidx random_seed_index();
        if ($urandom_range(0, 7) == 0) return t_sidx'($urandom_range(NUM_MAPS, 15));
        return t_sidx'($urandom_range(0, NUM_MAPS - 1));
    endfunction

    function automatic t_val random_seed_value();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'h0000_0001;
            3: return 32'hC000_0000;
            default: return t_val'($urandom);
        endcase
    endfunction

    // mostly pixel runs, with reseed bursts and the odd lone bad seed
    function automatic void queue_random_traffic(int target);
        int added;
        int n;
        added = 0;
        while (added < target) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    n = $urandom_range(1, 4);
                    repeat (n) push_seed(random_seed_index(), random_seed_value());
                    added += n;
                end
                2: begin
                    push_seed(t_sidx'($urandom_range(NUM_MAPS, 15)), t_val'($urandom));
                    added++;
                end
                default: begin
                    n = $urandom_range(1, 30);
                    repeat (n) push_pixel(t_pix'($urandom));
                    added += n;
                end
            endcase
        end
    endfunction

    function automatic void queue_directed();
        push_seed(t_sidx'(0), 32'h8000_0000);
        push_seed(t_sidx'(1), 32'hFFFF_FFFF);
        push_seed(t_sidx'(2), 32'h0000_0001);
        push_seed(t_sidx'(3), 32'h4000_0000);
        push_seed(t_sidx'(4), 32'hC000_0000);
        push_seed(t_sidx'(5), 32'h7FFF_FFFF);
        push_seed(t_sidx'(6), t_val'($urandom));
        push_seed(t_sidx'(7), t_val'($urandom));
        push_seed(t_sidx'(8), t_val'($urandom));
        push_seed(t_sidx'(9), 32'h0000_0000);
        // out-of-range index only restarts the map sequence
        push_seed(t_sidx'(15), 32'hFFFF_FFFF);
        push_pixel(8'h00);
        push_pixel(8'hFF);
        push_pixel(8'hAA);
        push_pixel(8'h55);
        repeat (8) push_pixel(t_pix'($urandom));
    endfunction

    task automatic apb_access(input t_paddr addr, input logic wr, input t_pdata data,
                              output t_pdata rd);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_start_map_readback();
        t_pdata rd;
        apb_access(ADDR_START_MAP, 1'b0, '0, rd);
        if (rd !== t_pdata'(start_map_cfg)) begin
            $error("start_map readback: expected 0x%08h, actual 0x%08h",
                   t_pdata'(start_map_cfg), rd);
            fail_count++;
        end
    endtask

    task automatic write_start_map(input t_cfg value);
        t_pdata rd;
        apb_access(ADDR_START_MAP, 1'b1, t_pdata'(value), rd);
        start_map_cfg = value;
        check_start_map_readback();
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || in_ch.valid || expected_cipher.size() != 0);
    endtask

    // input driver: bursts of transactions with random gaps
    always @(negedge i_clk) begin : drive_input
        cipher_item_t item;
        if (!in_ch.valid || in_taken) begin
            if (gap_left > 0 && !steady) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                item = pending_items.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.cmd        <= item.cmd;
                in_ch.seed_index <= item.seed_index;
                in_ch.seed_value <= item.seed_value;
                in_ch.pixel      <= item.pixel;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result sink: ready runs broken by short and occasional long stalls
    always @(negedge i_clk) begin : drive_output_ready
        if (steady) begin
            out_ch.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_ch.ready <= 1'b0;
        end else if (run_left > 0) begin
            run_left--;
            out_ch.ready <= 1'b1;
        end else begin
            run_left   = $urandom_range(0, 23);
            stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                     : $urandom_range(0, 4);
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : monitor
        t_pix want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= in_ch.valid && in_ch.ready;
            if (out_ch.valid && out_ch.ready) begin
                pixels_checked++;
                if (expected_cipher.size() == 0) begin
                    $error("cipher_pixel: expected none, actual 0x%02h", out_ch.cipher_pixel);
                    fail_count++;
                end else begin
                    want = expected_cipher.pop_front();
                    if (out_ch.cipher_pixel !== want) begin
                        $error("cipher_pixel: expected 0x%02h, actual 0x%02h",
                               want, out_ch.cipher_pixel);
                        fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                advance_cipher('{in_ch.cmd, in_ch.seed_index, in_ch.seed_value, in_ch.pixel});
            end
        end
    end

    initial begin
        t_cfg   settings [NUM_SETTINGS];
        t_pdata rd;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = CMD_SEED;
        in_ch.seed_index = '0;
        in_ch.seed_value = '0;
        in_ch.pixel      = '0;
        out_ch.ready     = 1'b0;
        in_taken         = 1'b0;
        steady           = 1'b0;
        burst_left       = 0;
        gap_left         = 0;
        run_left         = 0;
        stall_left       = 0;
        fail_count       = 0;
        seeds_seen       = 0;
        pixels_seen      = 0;
        pixels_checked   = 0;
        cur_map          = 0;
        group_pos        = '0;
        start_map_cfg    = '0;
        foreach (map_x[i]) map_x[i] = '0;

        settings[0] = t_cfg'(0);
        settings[1] = t_cfg'(NUM_MAPS - 1);
        settings[2] = t_cfg'(15);
        settings[3] = t_cfg'(NUM_MAPS);
        settings[4] = t_cfg'($urandom_range(0, 15));
        settings[5] = t_cfg'($urandom_range(1, NUM_MAPS - 2));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int ph = 0; ph < NUM_SETTINGS; ph++) begin
            // map values need no flush, but a seed may still be in flight
            wait_drained();
            repeat (8) @(posedge i_clk);
            steady = (ph == 3);
            write_start_map(settings[ph]);
            if (ph == 0) begin
                // write to an unmapped register must leave start_map alone
                apb_access(ADDR_UNMAPPED, 1'b1, t_pdata'(7), rd);
                check_start_map_readback();
                queue_directed();
            end
            queue_random_traffic(ITEMS_PER_RUN);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        $display("covered %0d seed and %0d pixel transactions over %0d start_map settings",
                 seeds_seen, pixels_seen, NUM_SETTINGS);
        $display("%0d ciphered pixels checked, %0d mismatches", pixels_checked, fail_count);
        if (fail_count == 0 && expected_cipher.size() == 0) begin
            $display("chaotic_map_pixel_xor_cipher_test passed");
        end else begin
            $display("chaotic_map_pixel_xor_cipher_test failed");
        end
        $finish;
    end

endmodule
